// ----- rtl/core/bba_pkg.sv -----
package bba_pkg;

   // Default geometry of the pool
   localparam int MAX_ORDER_DEF    = 16;
   localparam int MIN_ORDER_DEF    = 5;
   localparam int HEADER_BYTES_DEF = 16;

   // Fixed field widths
   localparam int ADDR_W  = 16;
   localparam int REQ_W   = 16;
   localparam int ORDER_W = 5;
   // request_bytes plus the largest header still fits here
   localparam int TOTAL_W = REQ_W + 1;

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

endpackage

// ----- rtl/core/bba_req_if.sv -----
interface bba_req_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [REQ_W-1:0]  request_bytes;
   logic [ADDR_W-1:0] release_address;

   modport source (output valid, output operation, output request_bytes,
                   output release_address, input ready);
   modport sink   (input valid, input operation, input request_bytes,
                   input release_address, output ready);
endinterface

// ----- rtl/core/bba_rsp_if.sv -----
interface bba_rsp_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] block_address;
   logic              success;

   modport source (output valid, output block_address, output success, input ready);
   modport sink   (input valid, input block_address, input success, output ready);
endinterface

// ----- rtl/core/buddy_block_allocator_core.sv -----
// Buddy allocator over a pool of 2^MAX_ORDER bytes starting at offset 0. An allocate
// of n bytes takes a block of order ceil(log2(n + HEADER_BYTES)) (at least MIN_ORDER),
// splitting a larger free block when needed, and returns the block offset plus
// HEADER_BYTES; a size of zero, an oversize request or an empty pool fails with
// success 0 and address 0. A free pushes the block back on the free list of the order
// recorded at allocation, without merging buddies; address 0 is ignored. Each order's
// LIFO free list is a head register plus a shared next-link RAM, and the recorded
// orders sit in a second RAM; both RAMs have a registered read port. A free runs the
// free and respond states; a free of address 0 or a request rejected on size goes
// straight to respond; an allocate with no free block runs search and respond; a
// granted allocate runs search, pop, f - k splits, where f is the order of the block
// found and k the order wanted, each split one write to the next-link RAM, then
// respond. The result goes to an output register, so a new transaction is taken
// while the last result waits. No clearing pass is needed after reset.
module buddy_block_allocator_core #(
   parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
   parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
   parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);
   import bba_pkg::*;

   localparam int IDX_W     = MAX_ORDER - MIN_ORDER;
   localparam int NUM_BLKS  = 1 << IDX_W;
   localparam int HEAD_W    = IDX_W + 1;
   localparam int OI_W      = $clog2(MAX_ORDER + 1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_POP    = 6'b000100,
      S_SPLIT  = 6'b001000,
      S_FREE   = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [HEAD_W-1:0]    heads_ff [MAX_ORDER+1];
   logic [HEAD_W-1:0]    heads_in [MAX_ORDER+1];
   logic                 fresh_ff, fresh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [ORDER_W-1:0]   k_ff, k_in;
   logic [ORDER_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]     blk_ff, blk_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic                 res_ok_ff, res_ok_in;

   // RAM ports
   logic                 nl_we;
   logic [IDX_W-1:0]     nl_waddr, nl_raddr;
   logic [HEAD_W-1:0]    nl_wdata, nl_rdata;
   logic                 bo_we;
   logic [ORDER_W-1:0]   bo_rdata;

   // Request decode
   logic [TOTAL_W-1:0]   total, total_m1;
   logic [ORDER_W-1:0]   k_raw, req_order;
   logic [31:0]          off_full;
   logic [IDX_W-1:0]     free_blk;

   // Datapath helpers
   logic                 found;
   logic [ORDER_W-1:0]   found_ord;
   logic [ORDER_W-1:0]   i_dn;
   logic [IDX_W-1:0]     split_blk;
   logic [31:0]          blk_byte;
   logic                 first_pop;
   logic                 ord_ok;
   logic                 out_free;

   // Order of an allocate: bit length of (n + header - 1), floored at MIN_ORDER
   always_comb begin
      total    = TOTAL_W'(req_chan.request_bytes) + TOTAL_W'(HEADER_BYTES);
      total_m1 = total - TOTAL_W'(1);
      k_raw    = '0;
      for (int j = 0; j < TOTAL_W; j++) begin
         if (total_m1[j]) begin
            k_raw = ORDER_W'(j + 1);
         end
      end
      req_order = (k_raw < ORDER_W'(MIN_ORDER)) ? ORDER_W'(MIN_ORDER) : k_raw;
   end

   // Block number of a freed address
   assign off_full = 32'(req_chan.release_address) - 32'(HEADER_BYTES);
   assign free_blk = off_full[MAX_ORDER-1:MIN_ORDER];

   // Lowest non-empty order at or above the wanted order
   always_comb begin
      found     = 1'b0;
      found_ord = '0;
      for (int o = MAX_ORDER; o >= 0; o--) begin
         if (heads_ff[o][IDX_W] && (ORDER_W'(o) >= k_ff)) begin
            found     = 1'b1;
            found_ord = ORDER_W'(o);
         end
      end
   end

   assign i_dn      = i_ff - ORDER_W'(1);
   assign split_blk = blk_ff + (IDX_W'(1) << (i_dn - ORDER_W'(MIN_ORDER)));
   assign blk_byte  = (32'(blk_ff) << MIN_ORDER) + 32'(HEADER_BYTES);
   // The reset block at the top order has no link written yet
   assign first_pop = fresh_ff && (i_ff == ORDER_W'(MAX_ORDER)) && (blk_ff == '0);
   assign ord_ok    = (bo_rdata >= ORDER_W'(MIN_ORDER)) && (bo_rdata <= ORDER_W'(MAX_ORDER));
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   // Control and next-state logic
   always_comb begin
      state_in     = state_ff;
      heads_in     = heads_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      blk_in       = blk_ff;
      res_addr_in  = res_addr_ff;
      res_ok_in    = res_ok_ff;
      nl_we        = 1'b0;
      nl_waddr     = blk_ff;
      nl_wdata     = '0;
      nl_raddr     = blk_ff;
      bo_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               k_in        = req_order;
               blk_in      = free_blk;
               res_addr_in = '0;
               res_ok_in   = 1'b1;
               if (req_chan.operation == OP_FREE) begin
                  state_in = (req_chan.release_address == '0) ? S_RESP : S_FREE;
               end else if ((req_chan.request_bytes == '0) ||
                            (req_order > ORDER_W'(MAX_ORDER))) begin
                  res_ok_in = 1'b0;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (found) begin
               i_in     = found_ord;
               blk_in   = heads_ff[found_ord[OI_W-1:0]][IDX_W-1:0];
               nl_raddr = heads_ff[found_ord[OI_W-1:0]][IDX_W-1:0];
               state_in = S_POP;
            end else begin
               res_ok_in = 1'b0;
               state_in  = S_RESP;
            end
         end
         S_POP: begin
            // unlink the head, record the order, prepare the grant
            heads_in[i_ff[OI_W-1:0]] = first_pop ? '0 : nl_rdata;
            if (first_pop) begin
               fresh_in = 1'b0;
            end
            bo_we       = 1'b1;
            res_addr_in = blk_byte[ADDR_W-1:0];
            res_ok_in   = 1'b1;
            state_in    = (i_ff > k_ff) ? S_SPLIT : S_RESP;
         end
         S_SPLIT: begin
            // push the upper half one order down
            nl_we                    = 1'b1;
            nl_waddr                 = split_blk;
            nl_wdata                 = heads_ff[i_dn[OI_W-1:0]];
            heads_in[i_dn[OI_W-1:0]] = {1'b1, split_blk};
            i_in                     = i_dn;
            if (i_dn == k_ff) begin
               state_in = S_RESP;
            end
         end
         S_FREE: begin
            if (ord_ok) begin
               nl_we                        = 1'b1;
               nl_wdata                     = heads_ff[bo_rdata[OI_W-1:0]];
               heads_in[bo_rdata[OI_W-1:0]] = {1'b1, blk_ff};
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = res_addr_ff;
               rsp_ok_in    = res_ok_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int o = 0; o <= MAX_ORDER; o++) begin
            heads_ff[o] <= (o == MAX_ORDER) ? {1'b1, IDX_W'(0)} : '0;
         end
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
      rsp_ok_ff   <= rsp_ok_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      blk_ff      <= blk_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
   end

   // Free-list links, one per block
   bba_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (NUM_BLKS)
   ) u_next_link (
      .clock   (clock),
      .wr_en   (nl_we),
      .wr_addr (nl_waddr),
      .wr_data (nl_wdata),
      .rd_addr (nl_raddr),
      .rd_data (nl_rdata)
   );

   // Order recorded at allocation, one per block
   bba_ram #(
      .WIDTH (ORDER_W),
      .DEPTH (NUM_BLKS)
   ) u_block_order (
      .clock   (clock),
      .wr_en   (bo_we),
      .wr_addr (blk_ff),
      .wr_data (k_ff),
      .rd_addr (free_blk),
      .rd_data (bo_rdata)
   );

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.block_address = rsp_addr_ff;
   assign rsp_chan.success       = rsp_ok_ff;
endmodule

// ----- rtl/core/bba_ram.sv -----
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/bba_checker.sv -----
module bba_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bba_pkg::ADDR_W-1:0] rsp_block_address,
   input logic                      rsp_success
);
   import bba_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Transactions taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A result that waits keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_address)
                                  && $stable(rsp_success))
      else $error("result changed while stalled");

   // No result without a transaction behind it
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without pending transaction");

   // At most one in the engine and one in the output register
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many transactions outstanding");

   // Input is refused while two transactions are outstanding
   a_refuse_full: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("input taken while engine and output are full");
endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_block_address (rsp_chan.block_address),
   .rsp_success       (rsp_chan.success)
);
